>>> rtl/wheel_speed_odometer_macros.svh
// ----------------------------------------------------------------------------
// Wheel speed odometer assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_ODOMETER_MACROS_SVH
`define WHEEL_SPEED_ODOMETER_MACROS_SVH

`ifndef ASSERT_OFF
// The condition must hold at every clock edge outside reset.
`define WSO_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition violated");
// The antecedent implies the consequent in the same cycle.
`define WSO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define WSO_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define WSO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/wso_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed odometer package
// Shared payload types, controller commands and constants.
// ----------------------------------------------------------------------------
package wso_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CIRC_W     = 16;
  localparam int unsigned HOLD_W     = 4;
  localparam int unsigned DIVIDEND_W = 38;  // 32-bit distance times 36
  localparam int unsigned DIV_STEPS  = DIVIDEND_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CIRC_W-1:0] CIRC_RESET   = CIRC_W'(2146);
  localparam logic [HOLD_W-1:0] HOLD_RESET   = HOLD_W'(3);
  localparam logic [5:0]        SPEED_FACTOR = 6'd36;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_CALC  = 1'b1;

  localparam logic REG_CIRC = 1'b0;
  localparam logic REG_HOLD = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_tenths_kmh;
    logic [DIST_W-1:0]  odometer_mm;
  } out_item_t;

  typedef struct packed {
    logic pulse_upd;   // record timestamp, add circumference
    logic idle_upd;    // idle calculate: step the idle counter
    logic calc_start;  // load dividend and divisor
    logic div_step;    // one restoring division step
    logic div_finish;  // commit speed, move reference time
    logic out_load;    // capture result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic elapsed_zero;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

>>> rtl/wso_datapath.sv
// ----------------------------------------------------------------------------
// Wheel speed odometer datapath
// Distance and time registers, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module wso_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wso_pkg::ctl_cmd_t           cmd,
  input  wso_pkg::in_item_t           in_item,
  input  logic [wso_pkg::CIRC_W-1:0]  circ_mm,
  input  logic [wso_pkg::HOLD_W-1:0]  idle_hold,
  output wso_pkg::dp_status_t         status,
  output wso_pkg::out_item_t          out_item
);
  import wso_pkg::*;

  logic [SPEED_W-1:0]    speed_r;
  logic [DIST_W-1:0]     total_r;
  logic [DIST_W-1:0]     interval_r;
  logic [TIME_W-1:0]     latest_r;
  logic [TIME_W-1:0]     reference_r;
  logic [HOLD_W-1:0]     idle_cnt_r;
  logic [TIME_W-1:0]     divisor_r;
  logic [TIME_W-1:0]     rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  out_item_t             out_r;

  logic [TIME_W-1:0]     elapsed;
  logic [DIVIDEND_W-1:0] dividend;
  logic [TIME_W:0]       shifted;
  logic [TIME_W:0]       diff;
  logic                  fits;
  logic [HOLD_W-1:0]     idle_inc;

  assign elapsed  = latest_r - reference_r;
  assign dividend = DIVIDEND_W'(interval_r) * DIVIDEND_W'(SPEED_FACTOR);
  assign status.elapsed_zero = (elapsed == '0);

  // The partial remainder stays below the divisor, so the shifted value fits 33 bits.
  assign shifted  = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits     = (shifted >= {1'b0, divisor_r});
  assign diff     = shifted - {1'b0, divisor_r};
  assign idle_inc = idle_cnt_r + HOLD_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      total_r     <= '0;
      interval_r  <= '0;
      latest_r    <= '0;
      reference_r <= '0;
      idle_cnt_r  <= '0;
    end else begin
      if (cmd.pulse_upd) begin
        latest_r   <= in_item.timestamp;
        total_r    <= total_r + DIST_W'(circ_mm);
        interval_r <= interval_r + DIST_W'(circ_mm);
      end
      if (cmd.idle_upd) begin
        if (idle_inc >= idle_hold) begin
          speed_r    <= '0;
          idle_cnt_r <= '0;
        end else begin
          idle_cnt_r <= idle_inc;
        end
      end
      if (cmd.div_finish) begin
        speed_r     <= (|quo_r[DIVIDEND_W-1:SPEED_W]) ? '1 : quo_r[SPEED_W-1:0];
        reference_r <= latest_r;
        interval_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_start) begin
      divisor_r <= elapsed;
      rem_r     <= '0;
      quo_r     <= dividend;
    end else if (cmd.div_step) begin
      rem_r <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
    if (cmd.out_load) begin
      out_r.speed_tenths_kmh <= speed_r;
      out_r.odometer_mm      <= total_r;
    end
  end

  assign out_item = out_r;

endmodule

>>> rtl/wso_controller.sv
// ----------------------------------------------------------------------------
// Wheel speed odometer controller
// Sequences each transaction and owns both channel handshakes.
// ----------------------------------------------------------------------------
module wso_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  output logic                out_valid,
  input  logic                out_ready,
  input  wso_pkg::dp_status_t status,
  output wso_pkg::ctl_cmd_t   cmd
);
  import wso_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_PULSE) begin
            cmd.pulse_upd = 1'b1;
            state_nxt     = S_OUT;
          end else if (status.elapsed_zero) begin
            cmd.idle_upd = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            cmd.calc_start = 1'b1;
            step_nxt       = '0;
            state_nxt      = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_finish = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/wheel_speed_odometer.sv
// ----------------------------------------------------------------------------
// Wheel speed odometer
// Bicycle speed and distance computer with an APB register port.
// ----------------------------------------------------------------------------
// Every transaction yields one result holding the current speed in 0.1 km/h
// and the total distance in mm. A wheel pulse is applied on acceptance and
// its result is then loaded into the output register, and so is a calculate
// request when no time has passed since the last calculation. A calculate
// request with elapsed time runs a restoring divider that retires one quotient
// bit per cycle over the 38-bit dividend: the request is accepted and loaded,
// then come 38 division steps, the speed is committed and finally the result
// is loaded into the output register. A result that is not taken holds the
// block in its load state until the output register frees up. Only one
// transaction is processed at a time, but a new one is accepted while the
// previous result still waits at the output register. The wheel circumference
// sits at address 0 and the idle hold count at address 4; write them only
// while the block is idle.
module wheel_speed_odometer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wso_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wso_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wso_pkg::*;

`include "wheel_speed_odometer_macros.svh"

  logic [CIRC_W-1:0] circ_r;
  logic [HOLD_W-1:0] hold_r;
  logic              cfg_wr;
  logic              reg_sel;
  ctl_cmd_t          cmd;
  dp_status_t        status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r <= CIRC_RESET;
      hold_r <= HOLD_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_CIRC) begin
        circ_r <= pwdata[CIRC_W-1:0];
      end else begin
        hold_r <= pwdata[HOLD_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_CIRC) ? 32'(circ_r) : 32'(hold_r);

  wso_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_data.operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  wso_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_data),
    .circ_mm   (circ_r),
    .idle_hold (hold_r),
    .status    (status),
    .out_item  (out_data)
  );

  // A division in flight must block new transactions.
  `WSO_ASSERT_IMPL(a_div_blocks_input, clk, rst_n, cmd.div_step, !in_ready)
  // A result is never loaded over one that has not been taken.
  `WSO_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || out_ready)
  // Datapath commands are issued one at a time.
  `WSO_ASSERT_ALWAYS(a_one_cmd, clk, rst_n,
    $onehot0({cmd.pulse_upd, cmd.idle_upd, cmd.calc_start, cmd.div_step, cmd.div_finish}))

endmodule

>>> tb/wheel_speed_odometer_tb.sv
// ----------------------------------------------------------------------------
// Wheel speed odometer testbench
// Drives wheel pulses and calculate requests through the valid/ready input,
// predicts the speed and distance reading of every transaction and checks the
// readings in order. The register port is exercised between phases with
// read-back.
// ----------------------------------------------------------------------------
module wheel_speed_odometer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wso_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  localparam int unsigned PHASE_ITEMS    = 225;
  localparam int unsigned HOLD_OFF_AT    = 300;
  localparam int unsigned HOLD_OFF_LEN   = 600;
  localparam int unsigned SCRIPT_LEN     = 23;

  typedef struct packed {
    logic      typed;
    in_item_t  item;
    out_item_t reading;
  } script_row_t;

  // Opening rides at reset settings. Readings are typed in while they stay
  // obvious; the rest come from the predictor.
  localparam script_row_t RIDE_SCRIPT [SCRIPT_LEN] = '{
    '{1'b1, '{OP_CALC,  32'hFFFF_FFFF}, '{16'd0,     32'd0}},
    '{1'b1, '{OP_PULSE, 32'h0000_0000}, '{16'd0,     32'd2146}},
    '{1'b1, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd2146}},
    '{1'b1, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd2146}},
    '{1'b1, '{OP_PULSE, 32'h0000_0001}, '{16'd0,     32'd4292}},
    '{1'b1, '{OP_CALC,  32'h0000_0000}, '{16'hFFFF,  32'd4292}},
    '{1'b1, '{OP_CALC,  32'h0000_0000}, '{16'hFFFF,  32'd4292}},
    '{1'b1, '{OP_CALC,  32'h0000_0000}, '{16'hFFFF,  32'd4292}},
    '{1'b1, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd4292}},
    '{1'b0, '{OP_PULSE, 32'd1001},      '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_PULSE, 32'hFFFF_FFFF}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_PULSE, 32'h0000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_PULSE, 32'h8000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_PULSE, 32'h7FFF_FFFF}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_PULSE, 32'h8000_0E0F}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'h0000_0000}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'hAAAA_AAAA}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_PULSE, 32'h5555_5555}, '{16'd0,     32'd0}},
    '{1'b0, '{OP_CALC,  32'h5555_5555}, '{16'd0,     32'd0}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state.
  logic [CIRC_W-1:0]  circ_mm = CIRC_RESET;
  logic [HOLD_W-1:0]  hold_count = HOLD_RESET;
  logic [SPEED_W-1:0] speed_now = '0;
  logic [DIST_W-1:0]  total_now = '0;
  logic [DIST_W-1:0]  interval_now = '0;
  logic [TIME_W-1:0]  last_pulse_ms = '0;
  logic [TIME_W-1:0]  ref_ms = '0;
  logic [HOLD_W-1:0]  idle_now = '0;

  out_item_t   pending_readings [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 59;
  int unsigned cycle_count = 0;
  logic [31:0] ride_ms = '0;

  wheel_speed_odometer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
    if (mismatch_count < 10) begin
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, got_val);
    end
    mismatch_count++;
  endtask

  // Applies one transaction to the predicted state and returns the reading.
  function automatic out_item_t odometer_next(input in_item_t item);
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       quotient;
    out_item_t         reading;
    if (item.operation == OP_PULSE) begin
      last_pulse_ms = item.timestamp;
      total_now     = total_now + DIST_W'(circ_mm);
      interval_now  = interval_now + DIST_W'(circ_mm);
    end else begin
      elapsed = last_pulse_ms - ref_ms;
      if (elapsed != '0) begin
        quotient  = (64'(interval_now) * 64'(SPEED_FACTOR)) / 64'(elapsed);
        speed_now = (quotient > 64'hFFFF) ? '1 : quotient[SPEED_W-1:0];
        ref_ms       = last_pulse_ms;
        interval_now = '0;
      end else begin
        idle_now = idle_now + 1'b1;
        // A hold count of zero clears the speed on every idle request.
        if (idle_now >= hold_count) begin
          speed_now = '0;
          idle_now  = '0;
        end
      end
    end
    reading.speed_tenths_kmh = speed_now;
    reading.odometer_mm      = total_now;
    return reading;
  endfunction

  // Offers one transaction and records its reading once it is accepted.
  task automatic send_item(input in_item_t item, input logic typed,
                           input out_item_t typed_reading);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = odometer_next(item);
    pending_readings.push_back(typed ? typed_reading : predicted);
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Writes one register with junk in the unused bits, then reads it back.
  task automatic write_register(input logic index, input logic [15:0] value);
    logic [31:0] junk;
    logic [15:0] mask;
    junk = $urandom;
    mask = (index == REG_CIRC) ? 16'hFFFF : 16'h000F;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {junk[31:16], (value & mask) | (junk[15:0] & ~mask)};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == REG_CIRC) begin
      circ_mm = value;
    end else begin
      hold_count = value[HOLD_W-1:0];
    end
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata[15:0] & mask) !== (value & mask)) begin
      note_mismatch("register read-back", 64'(value & mask), 64'(prdata[15:0] & mask));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly plausible rides: timestamps move forward, sometimes in quick
  // succession, sometimes repeat, and now and then jump anywhere.
  function automatic in_item_t random_item(input logic pulses_only);
    in_item_t    item;
    int unsigned pick;
    item.timestamp = $urandom;
    if (pulses_only || $urandom_range(99) < 52) begin
      item.operation = OP_PULSE;
      pick = $urandom_range(99);
      if (pick < 4) begin
        ride_ms = $urandom;
      end else if (pick < 10) begin
        ride_ms = ride_ms;
      end else if (pick < 25) begin
        ride_ms = ride_ms + $urandom_range(1, 20);
      end else begin
        ride_ms = ride_ms + $urandom_range(100, 3000);
      end
      item.timestamp = ride_ms;
    end else begin
      item.operation = OP_CALC;
    end
    return item;
  endfunction

  // Result side: checks readings in order and throttles out_ready. Once, it
  // holds off for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin
    static int unsigned results_seen  = 0;
    static int unsigned hold_off_left = 0;
    static logic        hold_off_done = 1'b0;
    out_item_t          wanted;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        note_mismatch("unexpected reading, odometer", 64'd0, 64'(out_data.odometer_mm));
      end else begin
        wanted = pending_readings.pop_front();
        if (out_data.speed_tenths_kmh !== wanted.speed_tenths_kmh) begin
          note_mismatch("speed_tenths_kmh", 64'(wanted.speed_tenths_kmh),
                        64'(out_data.speed_tenths_kmh));
        end
        if (out_data.odometer_mm !== wanted.odometer_mm) begin
          note_mismatch("odometer_mm", 64'(wanted.odometer_mm), 64'(out_data.odometer_mm));
        end
      end
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else if (!hold_off_done && results_seen == HOLD_OFF_AT) begin
      hold_off_done = 1'b1;
      hold_off_left = HOLD_OFF_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [15:0] circ_pick;
    logic [15:0] hold_pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < SCRIPT_LEN; row++) begin
      send_item(RIDE_SCRIPT[row].item, RIDE_SCRIPT[row].typed, RIDE_SCRIPT[row].reading);
    end
    drain_readings();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin circ_pick = 16'd2146;  hold_pick = 16'd3;  end
        1: begin circ_pick = 16'hFFFF;  hold_pick = 16'd15; end
        2: begin circ_pick = 16'd0;     hold_pick = 16'd1;  end
        3: begin circ_pick = 16'($urandom);  hold_pick = 16'd0;  end
        4: begin circ_pick = 16'd1;     hold_pick = 16'($urandom_range(1, 15)); end
        default: begin
          circ_pick = 16'($urandom);
          hold_pick = 16'($urandom_range(1, 15));
        end
      endcase
      write_register(REG_CIRC, circ_pick);
      write_register(REG_HOLD, hold_pick);
      case (phase / 2)
        0: begin send_idle_pct = 15; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      ride_ms = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(1'b0), 1'b0, '0);
      end
      drain_readings();
    end

    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
